// ===== sv/de_bruijn_pattern_engine_core_assert.svh =====
// Assertion macros for the de Bruijn pattern engine.
// Used by de_bruijn_pattern_engine_core.sv; no other dependencies.
`ifndef DE_BRUIJN_PATTERN_ENGINE_CORE_ASSERT_SVH
`define DE_BRUIJN_PATTERN_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication.
`define DBPE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dbpe assertion failed");

// Next-cycle implication.
`define DBPE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dbpe assertion failed");

`endif

// ===== sv/dbpe_pkg.sv =====
// Shared types, constants and helpers for the de Bruijn pattern engine.
// No dependencies.
package dbpe_pkg;

    localparam int ALPHABET_SIZE_DEF = 26;
    localparam int WINDOW_LENGTH_DEF = 4;
    localparam int MAX_RUN_DEF       = 64;

    localparam int DIGIT_W = 5;
    localparam int CUR_W   = 3;
    localparam int POS_W   = 19;
    localparam int CNT_W   = 7;
    localparam int PAT_W   = 32;

    localparam logic [7:0] ASCII_A = 8'h61;

    localparam logic ACT_GENERATE = 1'b0;
    localparam logic ACT_FIND     = 1'b1;

    typedef struct packed {
        logic             action;
        logic [POS_W-1:0] start_index;
        logic [CNT_W-1:0] char_count;
        logic [PAT_W-1:0] pattern;
    } in_beat_t;

    typedef struct packed {
        logic [7:0]       out_char;
        logic             past_end;
        logic [POS_W-1:0] found_position;
        logic             found;
        logic             last;
    } out_beat_t;

    typedef struct packed {
        logic               emit;
        logic               done;
        logic [DIGIT_W-1:0] digit;
    } lyn_status_t;

    // Bit p set when p divides n, for p in 1..7.
    function automatic logic [7:0] divisor_mask(input int n);
        logic [7:0] m;
        m = '0;
        for (int p = 1; p < 8; p++) begin
            for (int q = 1; q <= 8; q++) begin
                if (p * q == n) begin
                    m[p] = 1'b1;
                end
            end
        end
        return m;
    endfunction

endpackage

// ===== sv/dbpe_lyndon.sv =====
// FKM prenecklace stepper: one emit or one advance per step.
// Depends on dbpe_pkg.
module dbpe_lyndon #(
    parameter int ALPHABET_SIZE = dbpe_pkg::ALPHABET_SIZE_DEF,
    parameter int WINDOW_LENGTH = dbpe_pkg::WINDOW_LENGTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 restart,
    input  logic                 step_en,
    output dbpe_pkg::lyn_status_t status
);

    localparam logic [7:0] DIV_MASK = dbpe_pkg::divisor_mask(WINDOW_LENGTH);
    localparam logic [dbpe_pkg::DIGIT_W-1:0] TOP_DIGIT =
        dbpe_pkg::DIGIT_W'(ALPHABET_SIZE - 1);

    logic [dbpe_pkg::DIGIT_W-1:0] digit_reg [1:WINDOW_LENGTH];
    logic [dbpe_pkg::DIGIT_W-1:0] digit_next [1:WINDOW_LENGTH];
    logic [dbpe_pkg::CUR_W-1:0]   per_reg;
    logic [dbpe_pkg::CUR_W-1:0]   cur_reg;
    logic                         done_reg;
    logic [dbpe_pkg::CUR_W-1:0]   t_sel;
    logic [dbpe_pkg::DIGIT_W-1:0] cur_digit;
    logic                         emit;

    assign emit = !done_reg && (cur_reg <= per_reg) && DIV_MASK[per_reg];

    always_comb begin
        cur_digit = '0;
        for (int i = 1; i <= WINDOW_LENGTH; i++) begin
            if (int'(cur_reg) == i) begin
                cur_digit = digit_reg[i];
            end
        end
    end

    // Rightmost non-maximal digit, then increment and periodic copy.
    always_comb begin
        t_sel = '0;
        for (int i = 1; i <= WINDOW_LENGTH; i++) begin
            if (digit_reg[i] != TOP_DIGIT) begin
                t_sel = dbpe_pkg::CUR_W'(i);
            end
        end
        for (int i = 1; i <= WINDOW_LENGTH; i++) begin
            digit_next[i] = digit_reg[i];
            if (int'(t_sel) == i) begin
                digit_next[i] = digit_reg[i] + 1'b1;
            end
        end
        for (int j = 2; j <= WINDOW_LENGTH; j++) begin
            for (int m = 1; m < j; m++) begin
                if (t_sel != '0 && int'(t_sel) + m == j) begin
                    digit_next[j] = digit_next[m];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            for (int i = 1; i <= WINDOW_LENGTH; i++) begin
                digit_reg[i] <= '0;
            end
            per_reg  <= dbpe_pkg::CUR_W'(1);
            cur_reg  <= dbpe_pkg::CUR_W'(1);
            done_reg <= 1'b0;
        end else if (step_en) begin
            if (emit) begin
                cur_reg <= cur_reg + 1'b1;
            end else if (!done_reg) begin
                if (t_sel == '0) begin
                    done_reg <= 1'b1;
                end else begin
                    digit_reg <= digit_next;
                    per_reg   <= t_sel;
                    cur_reg   <= dbpe_pkg::CUR_W'(1);
                end
            end
        end
    end

    assign status.emit  = emit;
    assign status.done  = done_reg;
    assign status.digit = cur_digit;

endmodule

// ===== sv/de_bruijn_pattern_engine_core.sv =====
// De Bruijn pattern engine top level: item sequencer, match window, output register.
// Depends on dbpe_pkg, dbpe_lyndon and de_bruijn_pattern_engine_core_assert.svh.
//
// Usage:
//   s_valid/s_ready/s_payload take one item per beat. A generate item (action 0)
//   returns char_count beats (saturated to MAX_RUN, none for a count of 0), one
//   letter of B(ALPHABET_SIZE, WINDOW_LENGTH) per beat from start_index on, with
//   last on the final beat. Positions past the sequence give out_char 0, past_end 1.
//   A find item (action 1) returns one beat with found/found_position for the
//   first non-wrapping occurrence of the low WINDOW_LENGTH pattern bytes.
//   Each item restarts the sequence; the FKM stepper does one emit or one
//   prenecklace advance per cycle unless held. A generate item walks the
//   sequence through start_index plus char_count letters and the advances
//   passed on the way; a find item runs until the match or the sequence end.
//   s_ready is high only between items. Results sit in an output register;
//   while m_ready is low the sequencer holds and resumes when the beat is
//   taken.
//   aresetn (synchronous, active low) clears the sequencer and m_valid.
`include "de_bruijn_pattern_engine_core_assert.svh"

module de_bruijn_pattern_engine_core #(
    parameter int ALPHABET_SIZE = dbpe_pkg::ALPHABET_SIZE_DEF,
    parameter int WINDOW_LENGTH = dbpe_pkg::WINDOW_LENGTH_DEF,
    parameter int MAX_RUN       = dbpe_pkg::MAX_RUN_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dbpe_pkg::in_beat_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output dbpe_pkg::out_beat_t m_payload
);

    localparam int IDX_W  = WINDOW_LENGTH * dbpe_pkg::DIGIT_W + 1;
    localparam int FILL_W = $clog2(WINDOW_LENGTH + 1);
    localparam logic [dbpe_pkg::CNT_W-1:0] RUN_MAX = dbpe_pkg::CNT_W'(MAX_RUN);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_LENGTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SKIP,
        ST_EMIT,
        ST_FIND,
        ST_REPLY
    } state_t;

    state_t                         state_reg;
    logic [IDX_W-1:0]               idx_reg;
    logic [dbpe_pkg::CNT_W-1:0]     remain_reg;
    logic [dbpe_pkg::POS_W-1:0]     start_reg;
    logic [dbpe_pkg::PAT_W-1:0]     pat_reg;
    logic [7:0]                     win_reg [WINDOW_LENGTH];
    logic [7:0]                     win_next [WINDOW_LENGTH];
    logic [FILL_W-1:0]              fill_reg;
    logic [FILL_W-1:0]              fill_next;
    logic [dbpe_pkg::POS_W-1:0]     pos_reg;
    logic [dbpe_pkg::POS_W-1:0]     pos_next;
    logic                           hit_reg;
    logic                           m_valid_reg;
    dbpe_pkg::out_beat_t            m_payload_reg;
    dbpe_pkg::lyn_status_t          lyn;
    logic                           step_en;
    logic                           out_free;
    logic                           beat_load;
    logic                           match;
    logic                           before_start;
    logic [7:0]                     ch;
    logic [dbpe_pkg::CNT_W-1:0]     cnt_sat;

    dbpe_lyndon #(
        .ALPHABET_SIZE(ALPHABET_SIZE),
        .WINDOW_LENGTH(WINDOW_LENGTH)
    ) u_lyndon (
        .aclk   (aclk),
        .aresetn(aresetn),
        .restart(s_valid && s_ready),
        .step_en(step_en),
        .status (lyn)
    );

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_payload    = m_payload_reg;
    assign out_free     = !m_valid_reg || m_ready;
    assign beat_load    = ((state_reg == ST_EMIT) && out_free && (lyn.done || lyn.emit))
                          || ((state_reg == ST_REPLY) && out_free);
    assign ch           = dbpe_pkg::ASCII_A + 8'(lyn.digit);
    assign before_start = idx_reg < IDX_W'(start_reg);
    assign cnt_sat      = (s_payload.char_count > RUN_MAX) ? RUN_MAX : s_payload.char_count;

    always_comb begin
        unique case (state_reg)
            ST_SKIP:  step_en = !lyn.done && before_start;
            ST_EMIT:  step_en = out_free && !lyn.done;
            ST_FIND:  step_en = !lyn.done;
            default:  step_en = 1'b0;
        endcase
    end

    // Sliding window over the emitted letters.
    always_comb begin
        win_next  = win_reg;
        fill_next = fill_reg;
        pos_next  = pos_reg;
        if (fill_reg < FILL_FULL) begin
            for (int i = 0; i < WINDOW_LENGTH; i++) begin
                if (int'(fill_reg) == i) begin
                    win_next[i] = ch;
                end
            end
            fill_next = fill_reg + 1'b1;
        end else begin
            for (int i = 0; i < WINDOW_LENGTH - 1; i++) begin
                win_next[i] = win_reg[i + 1];
            end
            win_next[WINDOW_LENGTH - 1] = ch;
            pos_next = pos_reg + 1'b1;
        end
        match = (fill_next == FILL_FULL);
        for (int i = 0; i < WINDOW_LENGTH; i++) begin
            if (win_next[i] != pat_reg[8 * i +: 8]) begin
                match = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (beat_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        idx_reg   <= '0;
                        start_reg <= s_payload.start_index;
                        pat_reg   <= s_payload.pattern;
                        fill_reg  <= '0;
                        pos_reg   <= '0;
                        hit_reg   <= 1'b0;
                        remain_reg <= cnt_sat;
                        if (s_payload.action == dbpe_pkg::ACT_FIND) begin
                            state_reg <= ST_FIND;
                        end else if (cnt_sat != '0) begin
                            state_reg <= ST_SKIP;
                        end
                    end
                end
                ST_SKIP: begin
                    if (lyn.done || !before_start) begin
                        state_reg <= ST_EMIT;
                    end else if (lyn.emit) begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (out_free && (lyn.done || lyn.emit)) begin
                        m_payload_reg.out_char       <= lyn.done ? 8'd0 : ch;
                        m_payload_reg.past_end       <= lyn.done;
                        m_payload_reg.found_position <= '0;
                        m_payload_reg.found          <= 1'b0;
                        m_payload_reg.last           <= (remain_reg == dbpe_pkg::CNT_W'(1));
                        remain_reg                   <= remain_reg - 1'b1;
                        if (remain_reg == dbpe_pkg::CNT_W'(1)) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_FIND: begin
                    if (lyn.done) begin
                        state_reg <= ST_REPLY;
                    end else if (lyn.emit) begin
                        win_reg  <= win_next;
                        fill_reg <= fill_next;
                        pos_reg  <= pos_next;
                        if (match) begin
                            hit_reg   <= 1'b1;
                            state_reg <= ST_REPLY;
                        end
                    end
                end
                ST_REPLY: begin
                    if (out_free) begin
                        m_payload_reg.out_char       <= 8'd0;
                        m_payload_reg.past_end       <= 1'b0;
                        m_payload_reg.found_position <= hit_reg ? pos_reg : '0;
                        m_payload_reg.found          <= hit_reg;
                        m_payload_reg.last           <= 1'b1;
                        state_reg                    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `DBPE_ASSERT_IMP(a_idle_no_step, aclk, aresetn, state_reg == ST_IDLE, !step_en)
    `DBPE_ASSERT_IMP(a_find_beat_last, aclk, aresetn, m_valid_reg && m_payload_reg.found,
        m_payload_reg.last && m_payload_reg.out_char == 8'd0)
    `DBPE_ASSERT_IMP(a_past_end_zero, aclk, aresetn, m_valid_reg && m_payload_reg.past_end,
        m_payload_reg.out_char == 8'd0 && !m_payload_reg.found)
    `DBPE_ASSERT_NXT(a_final_beat, aclk, aresetn,
        state_reg == ST_EMIT && beat_load && remain_reg == dbpe_pkg::CNT_W'(1),
        state_reg == ST_IDLE && m_valid_reg && m_payload_reg.last)

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for de_bruijn_pattern_engine_core: a directed table, then random items.
// Depends on dbpe_pkg and the core RTL. Expected beats come from the typed table values or from
// a locally built B(26,4) sequence and a table of first window positions.
`timescale 1ns / 100ps

module testbench;

    localparam int ALPHA        = dbpe_pkg::ALPHABET_SIZE_DEF;
    localparam int WIN          = dbpe_pkg::WINDOW_LENGTH_DEF;
    localparam int RUN_MAX      = dbpe_pkg::MAX_RUN_DEF;
    localparam int SEQ_LEN      = ALPHA ** WIN;
    localparam int RANDOM_ITEMS = 80;
    localparam int QUIET_ITEMS  = 20;
    localparam int LONG_HOLD    = 400;
    localparam logic GEN        = dbpe_pkg::ACT_GENERATE;
    localparam logic FND        = dbpe_pkg::ACT_FIND;

    typedef struct {
        dbpe_pkg::in_beat_t         item;
        bit                         typed;
        logic [7:0]                 t_char;
        logic                       t_end;
        logic [dbpe_pkg::POS_W-1:0] t_pos;
        logic                       t_found;
    } table_row_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    dbpe_pkg::in_beat_t  s_payload;
    logic                m_valid;
    logic                m_ready;
    dbpe_pkg::out_beat_t m_payload;

    logic [7:0]          debruijn_seq [0:SEQ_LEN-1];
    int                  first_hit [0:SEQ_LEN-1];
    dbpe_pkg::out_beat_t expected_beats[$];
    table_row_t          stim_table[$];
    dbpe_pkg::out_beat_t want_beat;

    int mismatch_count = 0;
    int beats_checked  = 0;
    int gen_items      = 0;
    int find_items     = 0;
    int cycle_count    = 0;
    int cycle_limit    = 200000;
    bit idling_on      = 1'b1;
    bit long_hold_req  = 1'b0;

    de_bruijn_pattern_engine_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // FKM walk over prenecklaces, then index every linear window by its first position.
    initial begin : build_sequence
        logic [dbpe_pkg::DIGIT_W-1:0] digit [0:WIN];
        int prefix;
        int period;
        int t;
        int len;
        int key;
        bit exhausted;
        for (int j = 0; j <= WIN; j++) digit[j] = '0;
        prefix = 1;
        period = 1;
        len = 0;
        exhausted = 1'b0;
        while (!exhausted) begin
            if (prefix <= period && WIN % period == 0) begin
                debruijn_seq[len] = dbpe_pkg::ASCII_A + digit[prefix];
                len++;
                prefix++;
            end else begin
                t = WIN;
                while (t >= 1 && digit[t] == ALPHA - 1) t--;
                if (t == 0) begin
                    exhausted = 1'b1;
                end else begin
                    digit[t] = digit[t] + 1'b1;
                    period = t;
                    for (int j = t + 1; j <= WIN; j++) digit[j] = digit[j - t];
                    prefix = 1;
                end
            end
        end
        for (int i = 0; i < SEQ_LEN; i++) first_hit[i] = -1;
        for (int i = 0; i + WIN <= len; i++) begin
            key = 0;
            for (int k = 0; k < WIN; k++)
                key = key * ALPHA + (debruijn_seq[i + k] - dbpe_pkg::ASCII_A);
            if (first_hit[key] < 0) first_hit[key] = i;
        end
    end

    function automatic int find_position(logic [dbpe_pkg::PAT_W-1:0] pattern);
        int key;
        logic [7:0] b;
        key = 0;
        for (int k = 0; k < WIN; k++) begin
            b = pattern[8*k +: 8];
            if (b < dbpe_pkg::ASCII_A || b >= dbpe_pkg::ASCII_A + ALPHA) return -1;
            key = key * ALPHA + (b - dbpe_pkg::ASCII_A);
        end
        return first_hit[key];
    endfunction

    function automatic int beats_for(dbpe_pkg::in_beat_t item);
        if (item.action == FND) return 1;
        return (item.char_count > RUN_MAX) ? RUN_MAX : int'(item.char_count);
    endfunction

    function automatic void predict_beats(dbpe_pkg::in_beat_t item);
        dbpe_pkg::out_beat_t beat;
        int n;
        int pos;
        int hit;
        if (item.action == GEN) begin
            n = beats_for(item);
            for (int k = 0; k < n; k++) begin
                pos = int'(item.start_index) + k;
                beat = '0;
                if (pos < SEQ_LEN) begin
                    beat.out_char = debruijn_seq[pos];
                end else begin
                    beat.past_end = 1'b1;
                end
                beat.last = (k == n - 1);
                expected_beats.push_back(beat);
            end
        end else begin
            hit = find_position(item.pattern);
            beat = '0;
            if (hit >= 0) begin
                beat.found = 1'b1;
                beat.found_position = dbpe_pkg::POS_W'(hit);
            end
            beat.last = 1'b1;
            expected_beats.push_back(beat);
        end
    endfunction

    // Worst-case cycles for one item: sequence walk, stalled beats, sender gap; 4x margin.
    function automatic void add_budget(dbpe_pkg::in_beat_t item);
        int reach;
        int hit;
        if (item.action == GEN) begin
            reach = int'(item.start_index) + beats_for(item);
            if (reach > SEQ_LEN) reach = SEQ_LEN;
        end else begin
            hit = find_position(item.pattern);
            reach = (hit < 0) ? SEQ_LEN : hit + WIN;
        end
        cycle_limit += 4 * (reach / 10 * 12 + 200 + beats_for(item) * 21 + 20);
    endfunction

    function automatic table_row_t table_line(logic action, int start, int count,
                                              logic [dbpe_pkg::PAT_W-1:0] pattern, bit typed,
                                              logic [7:0] t_char, logic t_end, int t_pos,
                                              logic t_found);
        table_row_t row;
        row.item.action      = action;
        row.item.start_index = dbpe_pkg::POS_W'(start);
        row.item.char_count  = dbpe_pkg::CNT_W'(count);
        row.item.pattern     = pattern;
        row.typed            = typed;
        row.t_char           = t_char;
        row.t_end            = t_end;
        row.t_pos            = dbpe_pkg::POS_W'(t_pos);
        row.t_found          = t_found;
        return row;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%t mismatch %s: got %0h, want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic run_item(input table_row_t row);
        dbpe_pkg::out_beat_t beat;
        int n;
        add_budget(row.item);
        @(negedge aclk);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= row.item;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        if (row.typed) begin
            n = beats_for(row.item);
            for (int k = 0; k < n; k++) begin
                beat = '0;
                beat.out_char = row.t_char;
                beat.past_end = row.t_end;
                beat.found_position = row.t_pos;
                beat.found = row.t_found;
                beat.last = (k == n - 1);
                expected_beats.push_back(beat);
            end
        end else begin
            predict_beats(row.item);
        end
        if (row.item.action == GEN) gen_items++;
        else find_items++;
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                long_hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_beats.size() == 0) begin
                report_mismatch("beat with nothing expected", m_payload.out_char, 0);
            end else begin
                want_beat = expected_beats.pop_front();
                if (m_payload.out_char !== want_beat.out_char)
                    report_mismatch("out_char", m_payload.out_char, want_beat.out_char);
                if (m_payload.past_end !== want_beat.past_end)
                    report_mismatch("past_end", m_payload.past_end, want_beat.past_end);
                if (m_payload.found_position !== want_beat.found_position)
                    report_mismatch("found_position", m_payload.found_position,
                                    want_beat.found_position);
                if (m_payload.found !== want_beat.found)
                    report_mismatch("found", m_payload.found, want_beat.found);
                if (m_payload.last !== want_beat.last)
                    report_mismatch("last", m_payload.last, want_beat.last);
                beats_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > cycle_limit) begin
            $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
                     expected_beats.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int r;
        int start;
        int count;
        int p;
        logic action;
        logic [dbpe_pkg::PAT_W-1:0] pattern;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_payload = '0;

        //                               act  start   cnt  pattern       typ char   end pos    fnd
        stim_table.push_back(table_line(GEN, 0,      1,   32'h00000000, 1, 8'h61, 0, 0,      0));
        stim_table.push_back(table_line(GEN, 0,      4,   32'hFFFFFFFF, 1, 8'h61, 0, 0,      0));
        stim_table.push_back(table_line(GEN, 0,      0,   32'h00000000, 1, 8'h00, 0, 0,      0));
        stim_table.push_back(table_line(GEN, 1,      64,  32'h5A5A5A5A, 0, 8'h00, 0, 0,      0));
        stim_table.push_back(table_line(GEN, 3,      127, 32'h00000000, 0, 8'h00, 0, 0,      0));
        stim_table.push_back(table_line(GEN, 26,     64,  32'h00000000, 0, 8'h00, 0, 0,      0));
        stim_table.push_back(table_line(GEN, 200,    33,  32'h00000000, 0, 8'h00, 0, 0,      0));
        stim_table.push_back(table_line(GEN, 2700,   65,  32'h00000000, 0, 8'h00, 0, 0,      0));
        stim_table.push_back(table_line(GEN, 456970, 10,  32'h00000000, 0, 8'h00, 0, 0,      0));
        stim_table.push_back(table_line(GEN, 524287, 127, 32'hFFFFFFFF, 1, 8'h00, 1, 0,      0));
        stim_table.push_back(table_line(FND, 0,      0,   32'h61616161, 1, 8'h00, 0, 0,      1));
        stim_table.push_back(table_line(FND, 524287, 127, 32'h62616161, 1, 8'h00, 0, 1,      1));
        stim_table.push_back(table_line(FND, 7,      9,   32'h61626161, 0, 8'h00, 0, 0,      0));
        stim_table.push_back(table_line(FND, 1234,   64,  32'h61616162, 0, 8'h00, 0, 0,      0));
        stim_table.push_back(table_line(FND, 0,      1,   32'h64636261, 0, 8'h00, 0, 0,      0));
        stim_table.push_back(table_line(FND, 0,      1,   32'h7A7A7A7A, 1, 8'h00, 0, 456972, 1));
        // window that only exists across the wrap
        stim_table.push_back(table_line(FND, 0,      1,   32'h617A7A7A, 1, 8'h00, 0, 0,      0));
        stim_table.push_back(table_line(FND, 0,      1,   32'hFFFFFFFF, 1, 8'h00, 0, 0,      0));
        stim_table.push_back(table_line(FND, 0,      1,   32'h00000000, 1, 8'h00, 0, 0,      0));

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (stim_table[i]) run_item(stim_table[i]);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS - QUIET_ITEMS) idling_on = 1'b0;
            if (i == 25) begin
                long_hold_req = 1'b1;
                cycle_limit += 4 * LONG_HOLD;
            end
            if (i == 55) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                while (expected_beats.size() != 0) @(posedge aclk);
            end
            r = $urandom_range(0, 99);
            pattern = $urandom;
            if ($urandom_range(0, 1) == 0) begin
                action = GEN;
                if (r < 90) start = $urandom_range(0, 3000);
                else if (r < 98) start = $urandom_range(0, 30000);
                else start = $urandom_range(0, 524287);
                r = $urandom_range(0, 99);
                if (r < 85) count = $urandom_range(1, 64);
                else if (r < 95) count = $urandom_range(65, 127);
                else count = 0;
            end else begin
                action = FND;
                start = $urandom_range(0, 524287);
                count = $urandom_range(0, 127);
                if (r < 97) begin
                    p = (r < 87) ? $urandom_range(0, 3000) : $urandom_range(0, 30000);
                    for (int k = 0; k < WIN; k++) pattern[8*k +: 8] = debruijn_seq[p + k];
                end
            end
            run_item(table_line(action, start, count, pattern, 0, 8'h00, 0, 0, 0));
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        $display("ran %0d generate and %0d find items, %0d result beats checked",
                 gen_items, find_items, beats_checked);
        $display("incl. sequence end, wrap and absent patterns, count saturation, back-pressure");
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("status: fail");
        end
        $finish;
    end

endmodule
